>>> rtl/d2yp_pkg.sv
// ----------------------------------------------------------------------------
// d2yp_pkg: shared constants and functions for the direction-to-yaw/pitch block
// Field widths, datapath widths, angle limits and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package d2yp_pkg;

  // Stream payload widths.
  localparam int IN_W        = 32;
  localparam int OUT_W       = 25;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 56;

  // Angle in degrees, Q.16, with headroom for CORDIC overshoot.
  localparam int Q16_W = 26;

  // CORDIC operand magnitudes and the normalized operand width.
  localparam int MAG_W    = 63;
  localparam int NORM_TOP = 54;
  localparam int NORM_W   = NORM_TOP + 1;
  localparam int CORDIC_W = 60;

  // Integer square root of a 64-bit sum of squares.
  localparam int SQ_IN_W = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 35;

  // Pre-scale shift for the pitch magnitude.
  localparam int SHIFT_W = 5;

  // Output limits, degrees Q.16.
  localparam logic signed [Q16_W-1:0] YAW_LIM_Q16     = Q16_W'(180 * 65536);
  localparam logic signed [Q16_W-1:0] PITCH_LIM_Q16   = Q16_W'(90 * 65536);
  localparam logic signed [OUT_W-1:0] DEGEN_PITCH_Q16 = OUT_W'(180 * 65536);

  // atan(2^-i) in degrees, scaled by 2^32 and rounded.
  function automatic logic [63:0] atan_q32(input int unsigned idx);
    logic [63:0] t;
    case (idx)
      0:       t = 64'd193273528320;
      1:       t = 64'd114096026022;
      2:       t = 64'd60285206653;
      3:       t = 64'd30601712202;
      4:       t = 64'd15360239180;
      5:       t = 64'd7687607525;
      6:       t = 64'd3844741810;
      7:       t = 64'd1922488225;
      8:       t = 64'd961258780;
      9:       t = 64'd480631223;
      10:      t = 64'd240315841;
      11:      t = 64'd120157949;
      12:      t = 64'd60078978;
      13:      t = 64'd30039490;
      14:      t = 64'd15019745;
      15:      t = 64'd7509872;
      16:      t = 64'd3754936;
      17:      t = 64'd1877468;
      18:      t = 64'd938734;
      19:      t = 64'd469367;
      20:      t = 64'd234684;
      21:      t = 64'd117342;
      22:      t = 64'd58671;
      23:      t = 64'd29335;
      24:      t = 64'd14668;
      25:      t = 64'd7334;
      26:      t = 64'd3667;
      27:      t = 64'd1833;
      28:      t = 64'd917;
      29:      t = 64'd458;
      30:      t = 64'd229;
      31:      t = 64'd115;
      default: t = 64'd0;
    endcase
    return t;
  endfunction

  // Per-stage angle step with frac fraction bits, rounded half up.
  function automatic logic [63:0] atan_step(input int unsigned idx, input int unsigned frac);
    logic [63:0] t;
    t = atan_q32(idx);
    return (t + (64'd1 << (31 - frac))) >> (32 - frac);
  endfunction

endpackage

>>> rtl/d2yp_cordic.sv
// ----------------------------------------------------------------------------
// d2yp_cordic: pipelined vectoring CORDIC
// Normalizes a (y, x) pair given as magnitudes and signs, folds it into the
// right half plane and returns its angle in degrees, Q.16, unclamped.
// One pair can enter every cycle that en is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2yp_cordic #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [d2yp_pkg::MAG_W-1:0]         y_mag,
  input  logic                               y_neg,
  input  logic [d2yp_pkg::MAG_W-1:0]         x_mag,
  input  logic                               x_neg,
  output logic signed [d2yp_pkg::Q16_W-1:0]  angle
);
  import d2yp_pkg::*;

  localparam int ANG_W = FRACTION_BITS + 10;
  localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(64'd90 << FRACTION_BITS);

  typedef struct packed {
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] ux;
    logic [MAG_W-1:0] uy;
    logic             xn;
    logic             yn;
  } norm_t;

  // One step of the leading-zero shift: moves both magnitudes left by sh
  // when the top sh bits of the larger one are clear.
  function automatic norm_t norm_step(input norm_t v, input int sh);
    norm_t r;
    r = v;
    if ((v.m >> (MAG_W - sh)) == '0) begin
      r.m  = v.m << sh;
      r.ux = v.ux << sh;
      r.uy = v.uy << sh;
    end
    return r;
  endfunction

  norm_t n0, n1, n2, n3;
  logic [NORM_W-1:0] ux_n, uy_n;
  logic signed [CORDIC_W-1:0] xe, ye;
  logic signed [CORDIC_W-1:0] xs, ys;
  logic signed [CORDIC_W-1:0] cx [0:CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] cy [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0]    ca [0:CORDIC_STAGES];
  logic signed [Q16_W-1:0]    conv;

  // Larger magnitude, then three stages of the left-align shifter.
  always_ff @(posedge clk) begin
    if (en) begin
      n0.m  <= (x_mag > y_mag) ? x_mag : y_mag;
      n0.ux <= x_mag;
      n0.uy <= y_mag;
      n0.xn <= x_neg;
      n0.yn <= y_neg;
      n1    <= norm_step(norm_step(n0, 32), 16);
      n2    <= norm_step(norm_step(n1, 8), 4);
      n3    <= norm_step(norm_step(n2, 2), 1);
    end
  end

  // Keep the aligned word so its top bit lands at bit NORM_TOP; the low
  // bits drop, which truncates magnitudes that had to move right.
  assign ux_n = n3.ux[MAG_W-1 -: NORM_W];
  assign uy_n = n3.uy[MAG_W-1 -: NORM_W];
  assign xe   = signed'(CORDIC_W'(ux_n));
  assign ye   = signed'(CORDIC_W'(uy_n));

  // Sign restore, quadrant fold and the rotation stages.
  always_ff @(posedge clk) begin
    if (en) begin
      xs <= n3.xn ? -xe : xe;
      ys <= n3.yn ? -ye : ye;
      if (xs[CORDIC_W-1]) begin
        if (!ys[CORDIC_W-1]) begin
          cx[0] <= ys;
          cy[0] <= -xs;
          ca[0] <= ANG_90;
        end else begin
          cx[0] <= -ys;
          cy[0] <= xs;
          ca[0] <= -ANG_90;
        end
      end else begin
        cx[0] <= xs;
        cy[0] <= ys;
        ca[0] <= '0;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (!cy[i][CORDIC_W-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          ca[i+1] <= ca[i] + signed'(ANG_W'(atan_step(i, FRACTION_BITS)));
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          ca[i+1] <= ca[i] - signed'(ANG_W'(atan_step(i, FRACTION_BITS)));
        end
      end
    end
  end

  // Rescale the accumulated angle to Q.16, rounding half up when narrowing.
  generate
    if (FRACTION_BITS > 16) begin : g_round
      localparam int SH = FRACTION_BITS - 16;
      localparam logic signed [ANG_W:0] HALF = (ANG_W + 1)'(64'd1 << (SH - 1));
      logic signed [ANG_W:0] rnd;
      assign rnd  = $signed({ca[CORDIC_STAGES][ANG_W-1], ca[CORDIC_STAGES]}) + HALF;
      assign conv = Q16_W'(rnd >>> SH);
    end else begin : g_widen
      localparam int SH = 16 - FRACTION_BITS;
      assign conv = Q16_W'(ca[CORDIC_STAGES]) <<< SH;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= conv;
    end
  end

endmodule

>>> rtl/direction_to_yaw_pitch.sv
// ----------------------------------------------------------------------------
// direction_to_yaw_pitch: direction vector to yaw and pitch in degrees
// The longer path is the 32-step square-root pipeline feeding the pitch
// CORDIC; yaw and flags are delayed to match it. Throughput: one
// transaction per cycle; the whole pipeline advances whenever the
// output register is empty or being taken.
// Reset: rst clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module direction_to_yaw_pitch #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [d2yp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // dir_x, dir_y, dir_z
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [d2yp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // yaw_deg, pitch_deg, zeros
  output logic                                  m_axis_tuser    // degenerate
);
  import d2yp_pkg::*;

  // Stage map: 0 input, 1 magnitudes, 2 max, 3-4 pre-scale, 5 squares,
  // 6 sum, 7-38 square root, 39 pitch CORDIC operands, then the CORDIC,
  // then the output register.
  localparam int SQRT_STEPS = SQ_IN_W / 2;
  localparam int P_LAUNCH   = 7 + SQRT_STEPS;
  localparam int CLAT       = CORDIC_STAGES + 7;
  localparam int YAW_DLY    = P_LAUNCH - 1;
  localparam int SIDE_DLY   = P_LAUNCH + CLAT - 1;
  localparam int NSTG       = P_LAUNCH + CLAT + 2;
  localparam logic [IN_W-1:0] TOP_ONE = IN_W'(1) << (IN_W - 1);

  typedef struct packed {
    logic [IN_W-1:0]    m;
    logic [IN_W-1:0]    ua;
    logic [IN_W-1:0]    ub;
    logic [SHIFT_W-1:0] k;
  } align_t;

  typedef struct packed {
    logic [IN_W-1:0]    zm;
    logic [SHIFT_W-1:0] s;
  } zs_t;

  typedef struct packed {
    logic dg;
    logic zp;
  } side_t;

  // Left-align step for the pre-scale of |x| and |y|.
  function automatic align_t align_step(input align_t v, input int sh);
    align_t r;
    r = v;
    if ((v.m >> (IN_W - sh)) == '0) begin
      r.m  = v.m << sh;
      r.ua = v.ua << sh;
      r.ub = v.ub << sh;
      r.k  = v.k + SHIFT_W'(sh);
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_q16(
    input logic signed [Q16_W-1:0] v,
    input logic signed [Q16_W-1:0] lim
  );
    logic signed [Q16_W-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return OUT_W'(r);
  endfunction

  logic adv;
  logic [NSTG-1:0] vld;

  logic signed [IN_W-1:0] x0, y0, z0;
  logic [IN_W-1:0] ux1, uy1, zm1;
  logic xn1, yn1, zp1, dg1;
  logic [IN_W-1:0] m2, ua2, ub2, zm2;
  align_t a3, a4t;
  logic [IN_W-1:0] zm3;
  logic a4_pow2;
  logic [IN_W-1:0] a4, b4;
  zs_t zs4, zs5;
  logic [SQ_IN_W-1:0] aa5, bb5;

  logic [SQ_IN_W-1:0] sq_n    [0:SQRT_STEPS];
  logic [REM_W-1:0]   sq_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0]  sq_root [0:SQRT_STEPS];
  zs_t                sq_zs   [0:SQRT_STEPS];
  logic [REM_W-1:0]   rem_cat [0:SQRT_STEPS-1];
  logic [REM_W-1:0]   trial   [0:SQRT_STEPS-1];
  logic               take    [0:SQRT_STEPS-1];

  logic [MAG_W-1:0] py39, px39;
  side_t side_d [0:SIDE_DLY-1];
  logic signed [Q16_W-1:0] yaw_ang, pitch_ang;
  logic signed [Q16_W-1:0] yaw_d [0:YAW_DLY-1];
  side_t side_last;
  logic signed [OUT_W-1:0] yaw_o, pitch_o;
  logic dg_o;

  // Global advance: the pipeline moves when the output slot is free.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NSTG-1];
  assign m_axis_tdata  = OUT_TDATA_W'({pitch_o, yaw_o});
  assign m_axis_tuser  = dg_o;

  // Valid bits travel alongside the payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // Input, magnitudes, larger magnitude.
  always_ff @(posedge clk) begin
    if (adv) begin
      x0  <= s_axis_tdata[IN_W-1:0];
      y0  <= s_axis_tdata[2*IN_W-1:IN_W];
      z0  <= s_axis_tdata[3*IN_W-1:2*IN_W];
      ux1 <= x0[IN_W-1] ? unsigned'(-x0) : unsigned'(x0);
      uy1 <= y0[IN_W-1] ? unsigned'(-y0) : unsigned'(y0);
      zm1 <= z0[IN_W-1] ? unsigned'(-z0) : unsigned'(z0);
      xn1 <= x0[IN_W-1];
      yn1 <= y0[IN_W-1];
      zp1 <= !z0[IN_W-1] && (z0 != '0);
      dg1 <= (x0 == '0) && (y0 == '0);
      m2  <= (ux1 > uy1) ? ux1 : uy1;
      ua2 <= ux1;
      ub2 <= uy1;
      zm2 <= zm1;
    end
  end

  // Pre-scale: largest s with max(|x|,|y|) << s <= 2^31. Align the top bit
  // to bit 31, then back off by one unless the maximum is a power of two.
  assign a4t     = align_step(align_step(a3, 2), 1);
  assign a4_pow2 = (a4t.m == TOP_ONE);

  always_ff @(posedge clk) begin
    if (adv) begin
      a3     <= align_step(align_step(align_step(
                  align_t'{m: m2, ua: ua2, ub: ub2, k: '0}, 16), 8), 4);
      zm3    <= zm2;
      a4     <= a4_pow2 ? a4t.ua : (a4t.ua >> 1);
      b4     <= a4_pow2 ? a4t.ub : (a4t.ub >> 1);
      zs4.zm <= zm3;
      zs4.s  <= a4_pow2 ? a4t.k : (a4t.k - SHIFT_W'(1));
      aa5    <= SQ_IN_W'(a4) * SQ_IN_W'(a4);
      bb5    <= SQ_IN_W'(b4) * SQ_IN_W'(b4);
      zs5    <= zs4;
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  always_comb begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      rem_cat[j] = {sq_rem[j][REM_W-3:0], sq_n[j][SQ_IN_W-1 -: 2]};
      trial[j]   = REM_W'({sq_root[j], 2'b01});
      take[j]    = (rem_cat[j] >= trial[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n[0]    <= aa5 + bb5;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_zs[0]   <= zs5;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        sq_n[j+1]    <= sq_n[j] << 2;
        sq_rem[j+1]  <= take[j] ? (rem_cat[j] - trial[j]) : rem_cat[j];
        sq_root[j+1] <= {sq_root[j][ROOT_W-2:0], take[j]};
        sq_zs[j+1]   <= sq_zs[j];
      end
    end
  end

  // Pitch operands: (-z * 2^s, r) as magnitude and sign.
  always_ff @(posedge clk) begin
    if (adv) begin
      py39 <= MAG_W'(sq_zs[SQRT_STEPS].zm) << sq_zs[SQRT_STEPS].s;
      px39 <= MAG_W'(sq_root[SQRT_STEPS]);
    end
  end

  d2yp_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_yaw (
    .clk   (clk),
    .en    (adv),
    .y_mag (MAG_W'(uy1)),
    .y_neg (yn1),
    .x_mag (MAG_W'(ux1)),
    .x_neg (xn1),
    .angle (yaw_ang)
  );

  d2yp_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_pitch (
    .clk   (clk),
    .en    (adv),
    .y_mag (py39),
    .y_neg (side_d[P_LAUNCH-2].zp),
    .x_mag (px39),
    .x_neg (1'b0),
    .angle (pitch_ang)
  );

  // Delay lines that line the yaw result and the flags up with pitch.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= '{dg: dg1, zp: zp1};
      for (int k = 1; k < SIDE_DLY; k++) begin
        side_d[k] <= side_d[k-1];
      end
      yaw_d[0] <= yaw_ang;
      for (int k = 1; k < YAW_DLY; k++) begin
        yaw_d[k] <= yaw_d[k-1];
      end
    end
  end

  assign side_last = side_d[SIDE_DLY-1];

  // Output register: clamp, or the fixed answers when x and y are zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      dg_o <= side_last.dg;
      if (side_last.dg) begin
        yaw_o   <= '0;
        pitch_o <= side_last.zp ? DEGEN_PITCH_Q16 : '0;
      end else begin
        yaw_o   <= clamp_q16(yaw_d[YAW_DLY-1], YAW_LIM_Q16);
        pitch_o <= clamp_q16(pitch_ang, PITCH_LIM_Q16);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
      s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("Accepted transaction did not enter the first stage.");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (yaw_o <= OUT_W'(YAW_LIM_Q16)) && (yaw_o >= -OUT_W'(YAW_LIM_Q16)))
    else $error("Yaw outside +-180 degrees.");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !dg_o |->
        (pitch_o <= OUT_W'(PITCH_LIM_Q16)) && (pitch_o >= -OUT_W'(PITCH_LIM_Q16)))
    else $error("Pitch outside +-90 degrees for a regular vector.");

  a_degen_yaw: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && dg_o |-> (yaw_o == '0))
    else $error("Degenerate vector produced a nonzero yaw.");
`endif

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for direction_to_yaw_pitch
// Streams direction vectors into the block and checks every yaw, pitch and
// degenerate flag against a bit-exact vectoring CORDIC predictor kept here.
// Both stream sides stall at random, and the sender drains the pipe twice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import d2yp_pkg::*;

  // Bench copy of the block configuration, matched to the instance below.
  localparam int STAGES       = 24;
  localparam int FRAC         = 16;
  localparam int NORM_MSB     = 54;
  localparam int IDLE_PCT     = 26;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    logic signed [IN_W-1:0] z;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] x;
  } dir_vec_t;

  typedef struct {
    dir_vec_t vec;
    bit       hold;   // wait for an empty pipe before offering this vector
  } stim_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] yaw;
    logic signed [OUT_W-1:0] pitch;
    logic                    degen;
  } angles_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // dir_x, dir_y, dir_z
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // yaw_deg, pitch_deg, zeros
  logic                   m_axis_tuser;        // degenerate

  stim_item_t vector_queue[$];
  angles_t    pending_angles[$];
  stim_item_t cur_item;
  dir_vec_t   cur_vec;
  bit         vec_was_taken = 1'b0;
  int         vec_taken = 0;
  int         out_count = 0;
  int         degen_count = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;
  int         total_items = 0;

  direction_to_yaw_pitch #(
    .CORDIC_STAGES(STAGES),
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // atan(2^-i) in degrees scaled by 2^32, rounded.
  function automatic longint atan_deg_q32(input int idx);
    case (idx)
      0:  return 64'sd193273528320;
      1:  return 64'sd114096026022;
      2:  return 64'sd60285206653;
      3:  return 64'sd30601712202;
      4:  return 64'sd15360239180;
      5:  return 64'sd7687607525;
      6:  return 64'sd3844741810;
      7:  return 64'sd1922488225;
      8:  return 64'sd961258780;
      9:  return 64'sd480631223;
      10: return 64'sd240315841;
      11: return 64'sd120157949;
      12: return 64'sd60078978;
      13: return 64'sd30039490;
      14: return 64'sd15019745;
      15: return 64'sd7509872;
      16: return 64'sd3754936;
      17: return 64'sd1877468;
      18: return 64'sd938734;
      19: return 64'sd469367;
      20: return 64'sd234684;
      21: return 64'sd117342;
      22: return 64'sd58671;
      23: return 64'sd29335;
      24: return 64'sd14668;
      25: return 64'sd7334;
      26: return 64'sd3667;
      27: return 64'sd1833;
      28: return 64'sd917;
      29: return 64'sd458;
      30: return 64'sd229;
      default: return 64'sd115;
    endcase
  endfunction

  // Bitwise integer square root, rounded down.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = n;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC: angle of (px, py) in degrees with FRAC fraction bits.
  function automatic longint vector_angle(input longint py, input longint px);
    logic [63:0] mag_x;
    logic [63:0] mag_y;
    logic [63:0] mag_max;
    int          top;
    int          sh;
    longint      cx;
    longint      cy;
    longint      dx;
    longint      dy;
    longint      tmp;
    longint      acc;
    longint      step;
    mag_x   = (px < 0) ? -px : px;
    mag_y   = (py < 0) ? -py : py;
    mag_max = (mag_x > mag_y) ? mag_x : mag_y;
    if (mag_max == 0) return 0;
    top = 0;
    while (top < 63 && (mag_max >> (top + 1)) != 0) top++;
    // Bring the larger magnitude to a fixed top bit, keeping the ratio.
    if (top > NORM_MSB) begin
      mag_x = mag_x >> (top - NORM_MSB);
      mag_y = mag_y >> (top - NORM_MSB);
    end else begin
      mag_x = mag_x << (NORM_MSB - top);
      mag_y = mag_y << (NORM_MSB - top);
    end
    cx = longint'(mag_x);
    cy = longint'(mag_y);
    if (px < 0) cx = -cx;
    if (py < 0) cy = -cy;
    acc = 0;
    // Left half plane: turn by a quarter so the iterations converge.
    if (cx < 0) begin
      if (cy >= 0) begin
        tmp = cx;
        cx  = cy;
        cy  = -tmp;
        acc = longint'(90) <<< FRAC;
      end else begin
        tmp = cx;
        cx  = -cy;
        cy  = tmp;
        acc = -(longint'(90) <<< FRAC);
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      sh   = i & 31;
      step = (atan_deg_q32(sh) + (longint'(1) <<< (31 - FRAC))) >>> (32 - FRAC);
      dx   = cy >>> sh;
      dy   = cx >>> sh;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + step;
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - step;
      end
    end
    return acc;
  endfunction

  // Rescale an angle to Q.16 degrees and clamp it to +-lim_deg.
  function automatic longint to_out_q16(input longint ang, input longint lim_deg);
    longint lim;
    longint v;
    int     rs;
    lim = lim_deg * 65536;
    rs  = FRAC - 16;
    if (rs > 0) v = (ang + (longint'(1) <<< (rs - 1))) >>> rs;
    else        v = ang * (longint'(1) <<< (-rs));
    if (v > lim)  v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic angles_t predict_angles(input dir_vec_t d);
    angles_t     res;
    longint      xs;
    longint      ys;
    longint      zs;
    longint      yaw_v;
    longint      pitch_v;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] m;
    logic [63:0] root;
    int          sh;
    xs = d.x;
    ys = d.y;
    zs = d.z;
    if (xs == 0 && ys == 0) begin
      // No heading exists: flag it and report straight up as 180 degrees.
      yaw_v     = 0;
      pitch_v   = (zs > 0) ? 180 * 65536 : 0;
      res.degen = 1'b1;
    end else begin
      ux = (xs < 0) ? -xs : xs;
      uy = (ys < 0) ? -ys : ys;
      m  = (ux > uy) ? ux : uy;
      sh = 0;
      while ((m << 1) <= 64'h8000_0000) begin
        m  = m << 1;
        sh = sh + 1;
      end
      ux      = ux << sh;
      uy      = uy << sh;
      root    = int_sqrt(ux * ux + uy * uy);
      yaw_v   = to_out_q16(vector_angle(ys, xs), 180);
      pitch_v = to_out_q16(vector_angle(-zs * (longint'(1) <<< sh), longint'(root)), 90);
      res.degen = 1'b0;
    end
    res.yaw   = yaw_v[OUT_W-1:0];
    res.pitch = pitch_v[OUT_W-1:0];
    return res;
  endfunction

  task automatic queue_vector(input int x, input int y, input int z, input bit hold);
    stim_item_t it;
    it.vec.x = x;
    it.vec.y = y;
    it.vec.z = z;
    it.hold  = hold;
    vector_queue.push_back(it);
  endtask

  // Driver: new vectors and ready change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || vec_was_taken) begin
        vec_was_taken = 1'b0;
        if (vector_queue.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (vector_queue[0].hold && pending_angles.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!(vec_taken >= 300 && vec_taken < 450) &&
                     $urandom_range(0, 99) < IDLE_PCT) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_item = vector_queue.pop_front();
          cur_vec  = cur_item.vec;
          s_axis_tdata  <= {cur_vec.z, cur_vec.y, cur_vec.x};
          s_axis_tvalid <= 1'b1;
        end
      end
      if (out_count >= 300 && out_count < 450)
        m_axis_tready <= 1'b1;
      else
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: records accepted vectors, checks results, and guards progress.
  always @(posedge clk) begin
    angles_t exp_a;
    logic signed [OUT_W-1:0] got_yaw;
    logic signed [OUT_W-1:0] got_pitch;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_angles.push_back(predict_angles(cur_vec));
        vec_was_taken = 1'b1;
        vec_taken++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved     = 1'b1;
        got_yaw   = m_axis_tdata[OUT_W-1:0];
        got_pitch = m_axis_tdata[2*OUT_W-1:OUT_W];
        out_count++;
        if (m_axis_tuser) degen_count++;
        if (pending_angles.size() == 0) begin
          $error("unexpected result transaction: yaw_deg %0d, pitch_deg %0d",
                 got_yaw, got_pitch);
          fail_count++;
        end else begin
          exp_a = pending_angles.pop_front();
          if (got_yaw !== exp_a.yaw) begin
            $error("yaw_deg mismatch: expected %0d, got %0d", exp_a.yaw, got_yaw);
            fail_count++;
          end
          if (got_pitch !== exp_a.pitch) begin
            $error("pitch_deg mismatch: expected %0d, got %0d", exp_a.pitch, got_pitch);
            fail_count++;
          end
          if (m_axis_tuser !== exp_a.degen) begin
            $error("degenerate mismatch: expected %0d, got %0d", exp_a.degen, m_axis_tuser);
            fail_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind;
    int xv;
    int yv;
    int zv;

    // Directed vectors: degenerate axis, cardinal directions, extremes.
    queue_vector(0, 0, 0, 1'b0);
    queue_vector(0, 0, 1, 1'b0);
    queue_vector(0, 0, -1, 1'b0);
    queue_vector(0, 0, 32'sh7FFF_FFFF, 1'b0);
    queue_vector(0, 0, 32'sh8000_0000, 1'b0);
    queue_vector(65536, 0, 0, 1'b0);
    queue_vector(0, 65536, 0, 1'b0);
    queue_vector(-65536, 0, 0, 1'b0);
    queue_vector(0, -65536, 0, 1'b0);
    queue_vector(-65536, -1, 0, 1'b0);
    queue_vector(1, 0, 32'sh8000_0000, 1'b0);
    queue_vector(1, 0, 32'sh7FFF_FFFF, 1'b0);
    queue_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    queue_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    queue_vector(32'sh8000_0000, 0, 0, 1'b0);
    queue_vector(0, 32'sh8000_0000, 0, 1'b0);
    queue_vector(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    queue_vector(1, 1, 1, 1'b0);
    queue_vector(-1, 1, -1, 1'b0);
    queue_vector(65536, 65536, -92682, 1'b0);
    queue_vector(1, 32'sh7FFF_FFFF, 0, 1'b0);
    queue_vector(32'sh8000_0000, 1, 1, 1'b0);
    queue_vector(-1, 0, 32'sh8000_0000, 1'b0);
    queue_vector(-1, -1, -1, 1'b0);

    // Random vectors over several magnitude classes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      xv = $urandom();
      yv = $urandom();
      zv = $urandom();
      if (kind >= 40 && kind < 65) begin
        // Unit-scale vectors, as a normalized direction would be.
        xv = int'($urandom_range(0, 262144)) - 131072;
        yv = int'($urandom_range(0, 262144)) - 131072;
        zv = int'($urandom_range(0, 262144)) - 131072;
      end else if (kind >= 65 && kind < 80) begin
        // Tiny components stress the pre-scaling shift.
        xv = int'($urandom_range(0, 16)) - 8;
        yv = int'($urandom_range(0, 16)) - 8;
        if ($urandom_range(0, 1)) zv = int'($urandom_range(0, 16)) - 8;
      end else if (kind >= 80 && kind < 90) begin
        if ($urandom_range(0, 1)) xv = 0;
        else                      yv = 0;
      end else if (kind >= 90) begin
        xv = 0;
        yv = 0;
        if ($urandom_range(0, 1)) zv = int'($urandom_range(0, 4)) - 2;
      end
      queue_vector(xv, yv, zv, (n == 0) || (n == 500));
    end
    total_items = vector_queue.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (vec_taken < total_items) @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d vectors (%0d with no horizontal part): full-range, unit-scale,",
             out_count, degen_count);
    $display("tiny and axis-aligned inputs, random stalls on both sides, two pipe drains.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/d2yp_pkg.sv
rtl/d2yp_cordic.sv
rtl/direction_to_yaw_pitch.sv
bench/tb_top.sv
